FILE: sv/wec_pkg.sv
// ----------------------------------------------------------------------------
// wec_pkg
// Types and constants shared by the watermark eviction controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wec_pkg;

  // Field widths
  localparam int DATA_W          = 64;
  localparam int DISK_W          = 6;
  localparam int RATIO_W         = 16;
  localparam int RATIO_FRAC_BITS = 16;
  localparam int CFG_IDX_W       = 1;

  // Configuration register reset values
  localparam logic [RATIO_W-1:0] HIGH_RATIO_RST = 16'd58982;
  localparam logic [RATIO_W-1:0] LOW_RATIO_RST  = 16'd52429;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_RATIO = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_RATIO  = 1'b1;

  // Item modes
  localparam logic MODE_REPORT = 1'b0;
  localparam logic MODE_RETIRE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK           = 2'd0,
    STAT_INVALID_CFG  = 2'd1,
    STAT_ZERO_CAP     = 2'd2,
    STAT_NOT_EVICTING = 2'd3
  } status_t;

  typedef struct packed {
    logic              mode;
    logic [DISK_W-1:0] disk_index;
    logic [DATA_W-1:0] capacity_bytes;
    logic [DATA_W-1:0] used_bytes;
    logic [DATA_W-1:0] reserved_bytes;
    logic [DATA_W-1:0] footprint_bytes;
    logic              was_retired;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic              pressured;
    logic              evict_needed;
    logic [DATA_W-1:0] bytes_to_free;
    logic [DATA_W-1:0] usage_now;
    logic [DATA_W-1:0] released_bytes;
    logic              eviction_done;
  } out_item_t;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic ld_in;   // capture input transfer, issue state read
    logic mul_en;  // form partial products, retire subtraction
    logic wm_en;   // combine watermarks, select usage
    logic fin;     // decide, write back, load result register
    logic clr_we;  // clearing pass write
  } ctrl_cmd_t;

endpackage

`default_nettype wire

FILE: sv/wec_ram.sv
// ----------------------------------------------------------------------------
// wec_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module wec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/wec_ctrl.sv
// ----------------------------------------------------------------------------
// wec_ctrl
// Sequencer: clearing pass after reset, then one item at a time through
// read, multiply, combine and update steps; owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module wec_ctrl #(
  parameter int NUM_DISKS = 64
) (
  input  wire logic                                             clk,
  input  wire logic                                             rst_n,
  input  wire logic                                             in_valid,
  output logic                                                  in_ready,
  input  wire logic                                             out_ready,
  output logic                                                  out_valid,
  output wec_pkg::ctrl_cmd_t                                    cmd,
  output logic [((NUM_DISKS > 1) ? $clog2(NUM_DISKS) : 1)-1:0]  clr_addr
);

  import wec_pkg::*;

  localparam int AW = (NUM_DISKS > 1) ? $clog2(NUM_DISKS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_DISKS - 1);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_WM    = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            slot_free;

  assign slot_free = !out_valid_r || out_ready;

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    cmd         = '0;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (clr_cnt_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_WM;
      end
      ST_WM: begin
        cmd.wm_en = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // hold until the result register can take the result
        if (slot_free) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Result valid: set on finish, drop on output transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign clr_addr  = clr_cnt_r;

  // Checks
  a_fin_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> (!out_valid_r || out_ready))
    else $error("result loaded while previous result still waiting");

  a_accept_starts_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_MUL))
    else $error("accepted item did not start processing");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_we |-> !in_ready)
    else $error("input ready during clearing pass");

  a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.fin))
    else $error("result valid rose without a finished item");

endmodule

`default_nettype wire

FILE: sv/wec_dp.sv
// ----------------------------------------------------------------------------
// wec_dp
// Datapath: input register, per-disk state RAM, watermark multipliers,
// hysteresis decision and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wec_dp #(
  parameter int NUM_DISKS = 64
) (
  input  wire logic                                             clk,
  input  wire wec_pkg::ctrl_cmd_t                               cmd,
  input  wire logic [((NUM_DISKS > 1) ? $clog2(NUM_DISKS) : 1)-1:0] clr_addr,
  input  wire wec_pkg::in_item_t                                in_data,
  input  wire logic [wec_pkg::RATIO_W-1:0]                      high_ratio,
  input  wire logic [wec_pkg::RATIO_W-1:0]                      low_ratio,
  output wec_pkg::out_item_t                                    out_data
);

  import wec_pkg::*;

  localparam int AW     = (NUM_DISKS > 1) ? $clog2(NUM_DISKS) : 1;
  localparam int HALF_W = DATA_W / 2;
  localparam int PROD_W = HALF_W + RATIO_W;
  localparam int WIDE_W = DATA_W + RATIO_W;
  localparam int MEM_W  = 2 * DATA_W + 1;
  localparam int XW     = AW + DISK_W;

  // floor(product / 2^frac), saturated to 64 bits
  function automatic logic [DATA_W-1:0] wm_combine(input logic [PROD_W-1:0] p_hi,
                                                   input logic [PROD_W-1:0] p_lo);
    logic [WIDE_W-1:0] wide;
    logic [WIDE_W-1:0] shifted;
    wide    = {p_hi, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, p_lo};
    shifted = wide >> RATIO_FRAC_BITS;
    if (|shifted[WIDE_W-1:DATA_W]) begin
      return '1;
    end
    return shifted[DATA_W-1:0];
  endfunction

  in_item_t          in_r;
  logic [XW-1:0]     idx_ext;
  logic [XW-1:0]     in_idx_ext;
  logic [AW-1:0]     idx_addr;
  logic              idx_oor;

  // state RAM word: {flag, low threshold, usage}
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [MEM_W-1:0]  ram_wdata;
  logic [MEM_W-1:0]  ram_rdata;
  logic [DATA_W-1:0] rd_usage;

  logic [PROD_W-1:0] p_hh_r, p_hl_r, p_lh_r, p_ll_r;
  logic [DATA_W:0]   used_sum;
  logic [DATA_W-1:0] usage_sum_r;
  logic [DATA_W-1:0] ret_usage_r;
  logic [DATA_W-1:0] mem_low_r;
  logic              mem_flag_r;

  logic [DATA_W-1:0] usage_r;
  logic [DATA_W-1:0] high_wm_r;
  logic [DATA_W-1:0] low_r;

  logic              cfg_ok;
  logic              ge_low;
  logic              ge_high;
  logic [DATA_W-1:0] diff;
  logic              upd;
  logic              new_flag;
  out_item_t         res;
  out_item_t         out_r;

  // Capture the input transfer
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      in_r <= in_data;
    end
  end

  assign in_idx_ext = {{AW{1'b0}}, in_data.disk_index};
  assign idx_ext    = {{AW{1'b0}}, in_r.disk_index};
  assign idx_addr   = idx_ext[AW-1:0];
  assign idx_oor    = idx_ext >= XW'(NUM_DISKS);

  // Write port: clearing pass or item update
  assign ram_we    = cmd.clr_we || (cmd.fin && upd);
  assign ram_waddr = cmd.clr_we ? clr_addr : idx_addr;
  assign ram_wdata = cmd.clr_we ? '0 : {new_flag, low_r, usage_r};

  wec_ram #(
    .WIDTH (MEM_W),
    .DEPTH (NUM_DISKS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.ld_in),
    .raddr (in_idx_ext[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_usage = ram_rdata[DATA_W-1:0];
  assign used_sum = {1'b0, in_r.used_bytes} + {1'b0, in_r.reserved_bytes};

  // Partial products, saturating usage sum, retire subtraction
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p_hh_r      <= PROD_W'(in_r.capacity_bytes[DATA_W-1:HALF_W]) * PROD_W'(high_ratio);
      p_hl_r      <= PROD_W'(in_r.capacity_bytes[HALF_W-1:0]) * PROD_W'(high_ratio);
      p_lh_r      <= PROD_W'(in_r.capacity_bytes[DATA_W-1:HALF_W]) * PROD_W'(low_ratio);
      p_ll_r      <= PROD_W'(in_r.capacity_bytes[HALF_W-1:0]) * PROD_W'(low_ratio);
      usage_sum_r <= used_sum[DATA_W] ? '1 : used_sum[DATA_W-1:0];
      if (in_r.was_retired) begin
        ret_usage_r <= (rd_usage > in_r.footprint_bytes) ?
                       rd_usage - in_r.footprint_bytes : '0;
      end else begin
        ret_usage_r <= rd_usage;
      end
      mem_low_r   <= ram_rdata[2*DATA_W-1:DATA_W];
      mem_flag_r  <= ram_rdata[MEM_W-1];
    end
  end

  // Combine watermarks and pick the usage and low threshold for this mode
  always_ff @(posedge clk) begin
    if (cmd.wm_en) begin
      high_wm_r <= wm_combine(p_hh_r, p_hl_r);
      if (in_r.mode == MODE_RETIRE) begin
        usage_r <= ret_usage_r;
        low_r   <= mem_low_r;
      end else begin
        usage_r <= usage_sum_r;
        low_r   <= wm_combine(p_lh_r, p_ll_r);
      end
    end
  end

  assign cfg_ok  = (low_ratio != '0) && (low_ratio < high_ratio) &&
                   ((high_ratio >> RATIO_FRAC_BITS) == '0);
  assign ge_low  = usage_r >= low_r;
  assign ge_high = usage_r >= high_wm_r;
  assign diff    = usage_r - low_r;

  // Hysteresis decision and result
  always_comb begin
    res      = '0;
    upd      = 1'b0;
    new_flag = mem_flag_r;
    if (idx_oor) begin
      res.status = STAT_NOT_EVICTING;
    end else if (!cfg_ok) begin
      res.status    = STAT_INVALID_CFG;
      res.pressured = mem_flag_r;
    end else if ((in_r.mode == MODE_REPORT) && (in_r.capacity_bytes == '0)) begin
      res.status    = STAT_ZERO_CAP;
      res.pressured = mem_flag_r;
    end else if ((in_r.mode == MODE_RETIRE) && !mem_flag_r) begin
      res.status = STAT_NOT_EVICTING;
    end else begin
      upd = 1'b1;
      if (in_r.mode == MODE_RETIRE) begin
        new_flag           = ge_low;
        res.released_bytes = in_r.was_retired ? in_r.footprint_bytes : '0;
        res.eviction_done  = !ge_low;
      end else begin
        new_flag          = mem_flag_r ? ge_low : ge_high;
        res.eviction_done = mem_flag_r && !ge_low;
      end
      res.status       = STAT_OK;
      res.pressured    = new_flag;
      res.evict_needed = new_flag && ge_low;
      if (new_flag && ge_low) begin
        res.bytes_to_free = (&diff) ? '1 : diff + 1'b1;
      end
      res.usage_now = usage_r;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_r <= res;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

FILE: sv/watermark_eviction_controller.sv
// Items: an accepted item goes through read, multiply, combine and write-back
// steps on the single per-disk state RAM; in_ready stays low until the
// write-back step has loaded the result register, which waits until it is free.
// Reset: synchronous; a clearing pass zeroes every word of the state RAM
// with in_ready low; ratios return to 58982 and 52429; cfg writes always taken.
// ----------------------------------------------------------------------------
// watermark_eviction_controller
// Per-disk high/low watermark hysteresis controller for cache eviction.
// ----------------------------------------------------------------------------
`default_nettype none

module watermark_eviction_controller #(
  parameter int NUM_DISKS = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire wec_pkg::in_item_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output wec_pkg::out_item_t                     out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [wec_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [wec_pkg::RATIO_W-1:0]       cfg_wdata
);

  import wec_pkg::*;

  localparam int AW = (NUM_DISKS > 1) ? $clog2(NUM_DISKS) : 1;

  ctrl_cmd_t          cmd;
  logic [AW-1:0]      clr_addr;
  logic [RATIO_W-1:0] high_ratio_r;
  logic [RATIO_W-1:0] low_ratio_r;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_ratio_r <= HIGH_RATIO_RST;
      low_ratio_r  <= LOW_RATIO_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HIGH_RATIO: high_ratio_r <= cfg_wdata;
        REG_LOW_RATIO:  low_ratio_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  wec_ctrl #(
    .NUM_DISKS (NUM_DISKS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd),
    .clr_addr  (clr_addr)
  );

  wec_dp #(
    .NUM_DISKS (NUM_DISKS)
  ) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .clr_addr   (clr_addr),
    .in_data    (in_data),
    .high_ratio (high_ratio_r),
    .low_ratio  (low_ratio_r),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire
